### rtl/qrr_pkg.sv
// Package: payload types, register codes and fixed widths of the quaternion rotation block.
`timescale 1ns / 1ps

package qrr_pkg;

    // Component width and fraction bits (Q1.14 at 16 bits)
    localparam int COMPONENT_BITS = 16;
    localparam int FRAC_BITS      = COMPONENT_BITS - 2;

    // Configuration port
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Widths after block scaling: every magnitude lies at or below 2^30
    localparam int MAG_BITS  = 31;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int SUM_BITS  = 64;
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 2;

    typedef enum logic [2:0] {
        REG_REF_W   = 3'd0,
        REG_REF_X   = 3'd1,
        REG_REF_Y   = 3'd2,
        REG_REF_Z   = 3'd3,
        REG_RESTORE = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] in_w;
        logic signed [COMPONENT_BITS-1:0] in_x;
        logic signed [COMPONENT_BITS-1:0] in_y;
        logic signed [COMPONENT_BITS-1:0] in_z;
    } sample_t;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] out_w;
        logic signed [COMPONENT_BITS-1:0] out_x;
        logic signed [COMPONENT_BITS-1:0] out_y;
        logic signed [COMPONENT_BITS-1:0] out_z;
        logic                             zero_norm;
    } result_t;

    // Per-lane magnitudes and signs carried alongside the root search
    typedef struct packed {
        logic [3:0][MAG_BITS-1:0] mag;
        logic [3:0]               sgn;
        logic                     zero;
    } lane_t;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
        logic [SUM_BITS-1:0]  rad;
        lane_t                lane;
    } sqrt_t;

endpackage

### rtl/quaternion_reference_rotation.sv
// Top level: pipelined quaternion product with a reference, scaled to unit length.
// Stages: seven arithmetic stages, 32 root stages, one divide set-up stage,
//   15 quotient stages, one output register.
// Throughput: one request per cycle; the whole pipe advances together and holds
//   only while a finished result is held by result_stall.
// Reset: rst_n clears all valid bits and loads the reference with 1.0 + 0i + 0j + 0k
//   in relative mode; no clearing pass is needed.
`timescale 1ns / 1ps

module quaternion_reference_rotation (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qrr_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [qrr_pkg::DATA_BITS-1:0]        pwdata,
    output logic [qrr_pkg::DATA_BITS-1:0]        prdata,
    output logic                                 pready,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  qrr_pkg::sample_t                     sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output qrr_pkg::result_t                     result
);

    localparam int N     = qrr_pkg::COMPONENT_BITS;
    localparam int F     = qrr_pkg::FRAC_BITS;
    // Guard shift on partial products, only for very wide components
    localparam int G     = (2 * N > 61) ? (2 * N - 61) : 0;
    localparam int PW    = 2 * N + 1 - G;
    localparam int SW    = PW + 2;
    localparam int LW    = $clog2(SW);
    localparam int EW    = SW + 30;
    localparam int SHB   = SW + 28;
    localparam int AW    = $clog2(SHB + 1);
    localparam int MB    = qrr_pkg::MAG_BITS;
    localparam int RB    = qrr_pkg::ROOT_BITS;
    localparam int STEPS = F + 1;
    localparam int DW    = MB + F + 1;
    localparam int ROOT_STAGES = RB;

    typedef struct packed {
        logic [3:0][RB-1:0]    rem;
        logic [3:0][STEPS-1:0] dlo;
        logic [3:0][STEPS-1:0] quo;
        logic [RB-1:0]         root;
        logic [3:0]            sgn;
        logic                  zero;
    } div_t;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic signed [N-1:0] ref_w_reg, ref_x_reg, ref_y_reg, ref_z_reg;
    logic                restore_reg;
    logic                cfg_write;
    qrr_pkg::reg_idx_t   cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = qrr_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_w_reg   <= N'(16384);
            ref_x_reg   <= '0;
            ref_y_reg   <= '0;
            ref_z_reg   <= '0;
            restore_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                qrr_pkg::REG_REF_W:   ref_w_reg   <= pwdata[N-1:0];
                qrr_pkg::REG_REF_X:   ref_x_reg   <= pwdata[N-1:0];
                qrr_pkg::REG_REF_Y:   ref_y_reg   <= pwdata[N-1:0];
                qrr_pkg::REG_REF_Z:   ref_z_reg   <= pwdata[N-1:0];
                qrr_pkg::REG_RESTORE: restore_reg <= pwdata[0];
                default:              ;
            endcase
        end
    end

    // Read back the stored bits, zero-extended
    always_comb
    begin
        case (cfg_idx)
            qrr_pkg::REG_REF_W:   prdata = qrr_pkg::DATA_BITS'(ref_w_reg[N-1:0]);
            qrr_pkg::REG_REF_X:   prdata = qrr_pkg::DATA_BITS'(ref_x_reg[N-1:0]);
            qrr_pkg::REG_REF_Y:   prdata = qrr_pkg::DATA_BITS'(ref_y_reg[N-1:0]);
            qrr_pkg::REG_REF_Z:   prdata = qrr_pkg::DATA_BITS'(ref_z_reg[N-1:0]);
            qrr_pkg::REG_RESTORE: prdata = qrr_pkg::DATA_BITS'(restore_reg);
            default:              prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Flow control: every stage advances together unless the output
    // register holds a result that the far side stalls.
    //------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv          = !(out_valid_reg && result_stall);
    assign sample_stall = !adv;

    // Partial product with floor guard shift
    function automatic logic signed [PW-1:0] pp(input logic signed [N-1:0] a,
                                                input logic signed [N:0]   b);
        logic signed [2*N:0] full;
        full = a * b;
        return PW'(full >>> G);
    endfunction

    function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] v);
        return SW'(v);
    endfunction

    //------------------------------------------------------------------
    // Stage 1: sixteen partial products. Unless restore is set, the conjugate
    // is taken on the reference before multiplying, one bit wider so that -min fits.
    //------------------------------------------------------------------
    logic signed [N-1:0] op_a [4];
    logic signed [N:0]   op_b [4];
    logic signed [PW-1:0] prod_next [4][4];
    logic signed [PW-1:0] prod_reg  [4][4];
    logic                 v1_reg;

    always_comb
    begin
        op_a[0] = sample.in_w;
        op_a[1] = sample.in_x;
        op_a[2] = sample.in_y;
        op_a[3] = sample.in_z;
        op_b[0] = (N+1)'(ref_w_reg);
        op_b[1] = restore_reg ? (N+1)'(ref_x_reg) : -((N+1)'(ref_x_reg));
        op_b[2] = restore_reg ? (N+1)'(ref_y_reg) : -((N+1)'(ref_y_reg));
        op_b[3] = restore_reg ? (N+1)'(ref_z_reg) : -((N+1)'(ref_z_reg));
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_next[i][j] = pp(op_a[i], op_b[j]);
            end
        end
    end

    //------------------------------------------------------------------
    // Stage 2: Hamilton product sums
    //------------------------------------------------------------------
    logic signed [SW-1:0] p_next [4];
    logic signed [SW-1:0] p2_reg [4];
    logic                 v2_reg;

    always_comb
    begin
        p_next[0] = sx(prod_reg[0][0]) - sx(prod_reg[1][1])
                  - sx(prod_reg[2][2]) - sx(prod_reg[3][3]);
        p_next[1] = sx(prod_reg[0][1]) + sx(prod_reg[1][0])
                  + sx(prod_reg[2][3]) - sx(prod_reg[3][2]);
        p_next[2] = sx(prod_reg[0][2]) - sx(prod_reg[1][3])
                  + sx(prod_reg[2][0]) + sx(prod_reg[3][1]);
        p_next[3] = sx(prod_reg[0][3]) + sx(prod_reg[1][2])
                  - sx(prod_reg[2][1]) + sx(prod_reg[3][0]);
    end

    //------------------------------------------------------------------
    // Stage 3: largest magnitude
    //------------------------------------------------------------------
    logic [SW-1:0]        pm [4];
    logic [SW-1:0]        max_a, max_b, max_next;
    logic signed [SW-1:0] p3_reg [4];
    logic [SW-1:0]        max_reg;
    logic                 v3_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pm[i] = p2_reg[i][SW-1] ? SW'(-p2_reg[i]) : SW'(p2_reg[i]);
        end
        max_a    = (pm[0] > pm[1]) ? pm[0] : pm[1];
        max_b    = (pm[2] > pm[3]) ? pm[2] : pm[3];
        max_next = (max_a > max_b) ? max_a : max_b;
    end

    //------------------------------------------------------------------
    // Stage 4: leading one of the largest magnitude
    //------------------------------------------------------------------
    logic [LW-1:0]        lead_next;
    logic signed [SW-1:0] p4_reg [4];
    logic [LW-1:0]        lead_reg;
    logic                 zero4_reg;
    logic                 v4_reg;

    always_comb
    begin
        lead_next = '0;
        for (int b = 0; b < SW; b++)
        begin
            if (max_reg[b])
            begin
                lead_next = LW'(b);
            end
        end
    end

    //------------------------------------------------------------------
    // Stage 5: block scaling. Align left far enough that the shift is
    // exact, then take a fixed arithmetic right shift, which floors.
    // Net effect: shift by 29 - lead, so the largest lands in [2^29, 2^30].
    //------------------------------------------------------------------
    logic [AW-1:0]        amt;
    logic signed [EW-1:0] wide [4];
    logic signed [31:0]   ps_next [4];
    logic signed [31:0]   ps5_reg [4];
    logic                 zero5_reg;
    logic                 v5_reg;

    always_comb
    begin
        amt = AW'(SHB) - AW'(lead_reg);
        for (int i = 0; i < 4; i++)
        begin
            wide[i]    = EW'(p4_reg[i]);
            wide[i]    = (wide[i] <<< amt) >>> (SW - 1);
            ps_next[i] = wide[i][31:0];
        end
    end

    //------------------------------------------------------------------
    // Stage 6: magnitude, sign and square of each lane
    //------------------------------------------------------------------
    logic [31:0]                 mag_full [4];
    qrr_pkg::lane_t              lane_next;
    logic [qrr_pkg::SQ_BITS-1:0] sq_next [4];
    qrr_pkg::lane_t              lane6_reg;
    logic [qrr_pkg::SQ_BITS-1:0] sq6_reg [4];
    logic                        v6_reg;

    always_comb
    begin
        lane_next.zero = zero5_reg;
        for (int i = 0; i < 4; i++)
        begin
            mag_full[i]        = ps5_reg[i][31] ? 32'(-ps5_reg[i]) : 32'(ps5_reg[i]);
            lane_next.mag[i]   = mag_full[i][MB-1:0];
            lane_next.sgn[i]   = ps5_reg[i][31];
            sq_next[i]         = qrr_pkg::SQ_BITS'(mag_full[i][MB-1:0])
                               * qrr_pkg::SQ_BITS'(mag_full[i][MB-1:0]);
        end
    end

    //------------------------------------------------------------------
    // Stage 7: sum of squares, which seeds the root pipe
    //------------------------------------------------------------------
    qrr_pkg::sqrt_t sqrt_reg [ROOT_STAGES+1];
    logic           sv_reg   [ROOT_STAGES+1];
    qrr_pkg::sqrt_t seed_next;

    always_comb
    begin
        seed_next.rem  = '0;
        seed_next.root = '0;
        seed_next.lane = lane6_reg;
        seed_next.rad  = qrr_pkg::SUM_BITS'(sq6_reg[0]) + qrr_pkg::SUM_BITS'(sq6_reg[1])
                       + qrr_pkg::SUM_BITS'(sq6_reg[2]) + qrr_pkg::SUM_BITS'(sq6_reg[3]);
    end

    //------------------------------------------------------------------
    // Root stages: two radicand bits and one root bit per stage
    //------------------------------------------------------------------
    qrr_pkg::sqrt_t sqrt_next [ROOT_STAGES+1];

    always_comb
    begin
        logic [qrr_pkg::REM_BITS+1:0] cat;
        logic [qrr_pkg::REM_BITS+1:0] trial;
        sqrt_next[0] = seed_next;
        cat   = '0;
        trial = '0;
        for (int j = 1; j <= ROOT_STAGES; j++)
        begin
            sqrt_next[j]      = sqrt_reg[j-1];
            cat               = {sqrt_reg[j-1].rem, sqrt_reg[j-1].rad[qrr_pkg::SUM_BITS-1 -: 2]};
            trial             = (qrr_pkg::REM_BITS+2)'({sqrt_reg[j-1].root, 2'b01});
            sqrt_next[j].rad  = {sqrt_reg[j-1].rad[qrr_pkg::SUM_BITS-3:0], 2'b00};
            if (cat >= trial)
            begin
                sqrt_next[j].rem  = qrr_pkg::REM_BITS'(cat - trial);
                sqrt_next[j].root = {sqrt_reg[j-1].root[RB-2:0], 1'b1};
            end
            else
            begin
                sqrt_next[j].rem  = qrr_pkg::REM_BITS'(cat);
                sqrt_next[j].root = {sqrt_reg[j-1].root[RB-2:0], 1'b0};
            end
        end
    end

    //------------------------------------------------------------------
    // Divide set-up and quotient stages: q = (mag*2^F + r/2) / r,
    // one quotient bit per stage. The quotient never exceeds 2^F.
    //------------------------------------------------------------------
    div_t div_reg  [STEPS+1];
    div_t div_next [STEPS+1];
    logic dv_reg   [STEPS+1];

    always_comb
    begin
        logic [DW-1:0] dividend;
        logic [RB:0]   dcat;
        dividend         = '0;
        dcat             = '0;
        div_next[0].root = sqrt_reg[ROOT_STAGES].root;
        div_next[0].sgn  = sqrt_reg[ROOT_STAGES].lane.sgn;
        div_next[0].zero = sqrt_reg[ROOT_STAGES].lane.zero;
        for (int i = 0; i < 4; i++)
        begin
            dividend = {sqrt_reg[ROOT_STAGES].lane.mag[i], {F{1'b0}}}
                     + DW'(sqrt_reg[ROOT_STAGES].root >> 1);
            div_next[0].rem[i] = RB'(dividend[DW-1:STEPS]);
            div_next[0].dlo[i] = dividend[STEPS-1:0];
            div_next[0].quo[i] = '0;
        end
        for (int j = 1; j <= STEPS; j++)
        begin
            div_next[j] = div_reg[j-1];
            for (int i = 0; i < 4; i++)
            begin
                dcat = {div_reg[j-1].rem[i], div_reg[j-1].dlo[i][STEPS-1]};
                div_next[j].dlo[i] = {div_reg[j-1].dlo[i][STEPS-2:0], 1'b0};
                if (dcat >= {1'b0, div_reg[j-1].root})
                begin
                    div_next[j].rem[i] = RB'(dcat - {1'b0, div_reg[j-1].root});
                    div_next[j].quo[i] = {div_reg[j-1].quo[i][STEPS-2:0], 1'b1};
                end
                else
                begin
                    div_next[j].rem[i] = RB'(dcat);
                    div_next[j].quo[i] = {div_reg[j-1].quo[i][STEPS-2:0], 1'b0};
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Output register: apply signs, force zero on a zero norm
    //------------------------------------------------------------------
    qrr_pkg::result_t    res_next;
    qrr_pkg::result_t    res_reg;
    logic signed [N-1:0] comp [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            comp[i] = N'(div_reg[STEPS].quo[i]);
            if (div_reg[STEPS].sgn[i])
            begin
                comp[i] = -comp[i];
            end
            if (div_reg[STEPS].zero)
            begin
                comp[i] = '0;
            end
        end
        res_next.out_w     = comp[0];
        res_next.out_x     = comp[1];
        res_next.out_y     = comp[2];
        res_next.out_z     = comp[3];
        res_next.zero_norm = div_reg[STEPS].zero;
    end

    assign result_valid = out_valid_reg;
    assign result       = res_reg;

    //------------------------------------------------------------------
    // Valid bits: cleared by reset, advance with the pipe
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= ROOT_STAGES; j++)
            begin
                sv_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= STEPS; j++)
            begin
                dv_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= sample_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            sv_reg[0] <= v6_reg;
            for (int j = 1; j <= ROOT_STAGES; j++)
            begin
                sv_reg[j] <= sv_reg[j-1];
            end
            dv_reg[0] <= sv_reg[ROOT_STAGES];
            for (int j = 1; j <= STEPS; j++)
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
            out_valid_reg <= dv_reg[STEPS];
        end
    end

    // Payload registers: no reset, hold while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            p2_reg    <= p_next;
            p3_reg    <= p2_reg;
            max_reg   <= max_next;
            p4_reg    <= p3_reg;
            lead_reg  <= lead_next;
            zero4_reg <= (max_reg == '0);
            ps5_reg   <= ps_next;
            zero5_reg <= zero4_reg;
            lane6_reg <= lane_next;
            sq6_reg   <= sq_next;
            for (int j = 0; j <= ROOT_STAGES; j++)
            begin
                sqrt_reg[j] <= sqrt_next[j];
            end
            for (int j = 0; j <= STEPS; j++)
            begin
                div_reg[j] <= div_next[j];
            end
            res_reg <= res_next;
        end
    end

endmodule
